// ===== hdl/stvd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stvd_pkg
// Shared sizes, register indexes, configuration struct and address helpers
// for the tapped vector delay line.
// ----------------------------------------------------------------------------
package stvd_pkg;

  localparam int DEPTH         = 32;
  localparam int MAX_TAPS      = 8;
  localparam int MAX_VECTOR    = 8;
  localparam int SAMPLE_BITS   = 16;

  localparam int TABLE_ENTRIES = 8;
  localparam int DLY_W         = 5;
  localparam int SEEN_W        = 6;
  localparam int SEEN_MAX      = 63;

  localparam int ENTRIES = DEPTH * MAX_VECTOR;
  localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SLOT_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int POS_W   = (MAX_VECTOR > 1) ? $clog2(MAX_VECTOR) : 1;
  localparam int LEN_W   = $clog2(MAX_VECTOR + 1);
  localparam int TAP_LIM = (MAX_TAPS < TABLE_ENTRIES) ? MAX_TAPS : TABLE_ENTRIES;
  localparam int TAPC_W  = (TAP_LIM > 1) ? $clog2(TAP_LIM) : 1;
  localparam int TAPN_W  = $clog2(TAP_LIM + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_TABLE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EMIT_EARLY    = 2'd3;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(ENTRIES - 1);
  localparam logic [SEEN_W-1:0] SEEN_TOP  = SEEN_W'(SEEN_MAX);

  typedef struct packed {
    logic [LEN_W-1:0]                      eff_len;
    logic [TAPN_W-1:0]                     eff_taps;
    logic [TABLE_ENTRIES*DLY_W-1:0]        tap_table;
    logic                                  emit_early;
    logic [SLOT_W-1:0]                     max_delay;
  } stvd_cfg_t;

  function automatic logic [SLOT_W-1:0] tap_delay(
    input logic [TABLE_ENTRIES*DLY_W-1:0] tbl,
    input logic [TAPC_W-1:0]              k
  );
    logic [DLY_W-1:0] raw;
    raw = tbl[32'(k) * DLY_W +: DLY_W];
    if (32'(raw) >= DEPTH) begin
      return SLOT_LAST;
    end
    return SLOT_W'(raw);
  endfunction

  function automatic logic [ADDR_W-1:0] row_addr(
    input logic [SLOT_W-1:0] slot,
    input logic [POS_W-1:0]  pos
  );
    return ADDR_W'(32'(slot) * MAX_VECTOR + 32'(pos));
  endfunction

endpackage

// ===== hdl/stvd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stvd_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module stvd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/stvd_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stvd_seq
// Write and read sequencer around the history RAM: clear pass, element
// writes, per-vector tap/element read walk and the output word register.
// ----------------------------------------------------------------------------
module stvd_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  stvd_pkg::stvd_cfg_t         cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [15:0]          in_sample,
  output logic                        ram_we,
  output logic [stvd_pkg::ADDR_W-1:0] ram_waddr,
  output logic [stvd_pkg::SAMPLE_BITS-1:0] ram_wdata,
  output logic                        ram_re,
  output logic [stvd_pkg::ADDR_W-1:0] ram_raddr,
  input  logic [stvd_pkg::SAMPLE_BITS-1:0] ram_rdata,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [15:0]          out_value,
  output logic [2:0]                  out_tap_index,
  output logic [2:0]                  out_element_index,
  output logic                        out_ready_res,
  output logic                        out_last
);
  import stvd_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [SLOT_W-1:0] newest_r, newest_nxt;
  logic [SEEN_W-1:0] seen_r, seen_nxt;
  logic              mark_r, mark_nxt;
  logic [TAPC_W-1:0] k_r, k_nxt;
  logic [POS_W-1:0]  i_r, i_nxt;

  logic              p1_valid_r, p1_valid_nxt;
  logic              p1_marker_r, p1_marker_nxt;
  logic [2:0]        p1_tap_r, p1_tap_nxt;
  logic [2:0]        p1_elem_r, p1_elem_nxt;
  logic              p1_last_r, p1_last_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [15:0]       out_value_r, out_value_nxt;
  logic [2:0]        out_tap_r, out_tap_nxt;
  logic [2:0]        out_elem_r, out_elem_nxt;
  logic              out_res_r, out_res_nxt;
  logic              out_last_r, out_last_nxt;

  logic              accept;
  logic              vec_end;
  logic [SLOT_W-1:0] slot_next;
  logic [SEEN_W-1:0] seen_inc;
  logic              out_free;
  logic              p1_move;
  logic              issue;
  logic              elem_last;
  logic              tap_last;
  logic              word_last;
  logic [SLOT_W-1:0] dly;
  logic [SLOT_W-1:0] src_slot;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign vec_end   = (LEN_W'(pos_r) + LEN_W'(1)) >= cfg.eff_len;
  assign slot_next = (newest_r == SLOT_LAST) ? '0 : newest_r + SLOT_W'(1);
  assign seen_inc  = (seen_r == SEEN_TOP) ? seen_r : seen_r + SEEN_W'(1);

  assign out_free  = !out_valid_r || out_ready;
  assign p1_move   = p1_valid_r && out_free;
  assign issue     = (state_r == ST_EMIT) && (!p1_valid_r || out_free);
  assign elem_last = (LEN_W'(i_r) + LEN_W'(1)) == cfg.eff_len;
  assign tap_last  = (TAPN_W'(k_r) + TAPN_W'(1)) == cfg.eff_taps;
  assign word_last = mark_r || (elem_last && tap_last);

  assign dly       = tap_delay(cfg.tap_table, k_r);
  assign src_slot  = (newest_r >= dly) ? newest_r - dly
                                       : newest_r + SLOT_W'(DEPTH) - dly;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = row_addr(slot_next, pos_r);
    ram_wdata = SAMPLE_BITS'(in_sample);
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else if (accept) begin
      ram_we = 1'b1;
    end
  end

  assign ram_re    = issue && !mark_r;
  assign ram_raddr = row_addr(src_slot, i_r);

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    pos_nxt     = pos_r;
    newest_nxt  = newest_r;
    seen_nxt    = seen_r;
    mark_nxt    = mark_r;
    k_nxt       = k_r;
    i_nxt       = i_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == ADDR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (vec_end) begin
            pos_nxt    = '0;
            newest_nxt = slot_next;
            seen_nxt   = seen_inc;
            mark_nxt   = !(cfg.emit_early || (32'(seen_inc) > 32'(cfg.max_delay)));
            k_nxt      = '0;
            i_nxt      = '0;
            state_nxt  = ST_EMIT;
          end else begin
            pos_nxt = pos_r + POS_W'(1);
          end
        end
      end
      ST_EMIT: begin
        if (issue) begin
          if (word_last) begin
            state_nxt = ST_IDLE;
          end else if (elem_last) begin
            i_nxt = '0;
            k_nxt = k_r + TAPC_W'(1);
          end else begin
            i_nxt = i_r + POS_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    p1_valid_nxt  = p1_valid_r;
    p1_marker_nxt = p1_marker_r;
    p1_tap_nxt    = p1_tap_r;
    p1_elem_nxt   = p1_elem_r;
    p1_last_nxt   = p1_last_r;
    if (p1_move) begin
      p1_valid_nxt = 1'b0;
    end
    if (issue) begin
      p1_valid_nxt  = 1'b1;
      p1_marker_nxt = mark_r;
      p1_tap_nxt    = mark_r ? 3'd0 : 3'(k_r);
      p1_elem_nxt   = mark_r ? 3'd0 : 3'(i_r);
      p1_last_nxt   = word_last;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_tap_nxt   = out_tap_r;
    out_elem_nxt  = out_elem_r;
    out_res_nxt   = out_res_r;
    out_last_nxt  = out_last_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (p1_move) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = p1_marker_r ? 16'd0 : 16'(ram_rdata);
      out_tap_nxt   = p1_tap_r;
      out_elem_nxt  = p1_elem_r;
      out_res_nxt   = !p1_marker_r;
      out_last_nxt  = p1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      pos_r       <= '0;
      newest_r    <= '0;
      seen_r      <= '0;
      mark_r      <= 1'b0;
      k_r         <= '0;
      i_r         <= '0;
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      pos_r       <= pos_nxt;
      newest_r    <= newest_nxt;
      seen_r      <= seen_nxt;
      mark_r      <= mark_nxt;
      k_r         <= k_nxt;
      i_r         <= i_nxt;
      p1_valid_r  <= p1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p1_marker_r <= p1_marker_nxt;
    p1_tap_r    <= p1_tap_nxt;
    p1_elem_r   <= p1_elem_nxt;
    p1_last_r   <= p1_last_nxt;
    out_value_r <= out_value_nxt;
    out_tap_r   <= out_tap_nxt;
    out_elem_r  <= out_elem_nxt;
    out_res_r   <= out_res_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_value         = signed'(out_value_r);
  assign out_tap_index     = out_tap_r;
  assign out_element_index = out_elem_r;
  assign out_ready_res     = out_res_r;
  assign out_last          = out_last_r;

endmodule

// ===== hdl/selectable_tap_vector_delay_line_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selectable_tap_vector_delay_line_unit
// Tapped vector delay line with a programmable tap map over a ring of the
// last DEPTH sample vectors held in one RAM.
// ----------------------------------------------------------------------------
// Each input word carries one sample element. The word that completes a
// vector starts an output walk: tap_count x vector_length result words (or a
// single not-ready marker word) leave at one word per cycle while out_ready
// is high, paced by the single read port of the history RAM, and no input
// word is taken until the walk has issued its last word; the first result
// is registered through the read stage and the output word register. After
// reset the block clears all 256 history RAM entries (DEPTH x MAX_VECTOR),
// holding in_ready low; configuration writes are taken during the clear pass.
// ----------------------------------------------------------------------------
module selectable_tap_vector_delay_line_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [stvd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [stvd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [15:0]              in_sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [15:0]              out_value,
  output logic [2:0]                      out_tap_index,
  output logic [2:0]                      out_element_index,
  output logic                            out_ready_res,
  output logic                            out_last
);
  import stvd_pkg::*;

  logic [3:0]                     vector_length_r;
  logic [3:0]                     tap_count_r;
  logic [TABLE_ENTRIES*DLY_W-1:0] tap_table_r;
  logic                           emit_early_r;

  stvd_cfg_t cfg;

  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [SAMPLE_BITS-1:0] ram_wdata;
  logic                   ram_re;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vector_length_r <= 4'd1;
      tap_count_r     <= 4'd1;
      tap_table_r     <= '0;
      emit_early_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VECTOR_LENGTH: vector_length_r <= cfg_wdata[3:0];
        REG_TAP_COUNT:     tap_count_r     <= cfg_wdata[3:0];
        REG_TAP_TABLE:     tap_table_r     <= cfg_wdata[TABLE_ENTRIES*DLY_W-1:0];
        REG_EMIT_EARLY:    emit_early_r    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    logic [SLOT_W-1:0] d;
    cfg.tap_table  = tap_table_r;
    cfg.emit_early = emit_early_r;

    if (vector_length_r == 4'd0) begin
      cfg.eff_len = LEN_W'(1);
    end else if (32'(vector_length_r) > MAX_VECTOR) begin
      cfg.eff_len = LEN_W'(MAX_VECTOR);
    end else begin
      cfg.eff_len = LEN_W'(vector_length_r);
    end

    if (tap_count_r == 4'd0) begin
      cfg.eff_taps = TAPN_W'(1);
    end else if (32'(tap_count_r) > TAP_LIM) begin
      cfg.eff_taps = TAPN_W'(TAP_LIM);
    end else begin
      cfg.eff_taps = TAPN_W'(tap_count_r);
    end

    cfg.max_delay = '0;
    for (int k = 0; k < TAP_LIM; k++) begin
      d = tap_delay(tap_table_r, TAPC_W'(k));
      if ((k < 32'(cfg.eff_taps)) && (d > cfg.max_delay)) begin
        cfg.max_delay = d;
      end
    end
  end

  stvd_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  stvd_seq u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample         (in_sample),
    .ram_we            (ram_we),
    .ram_waddr         (ram_waddr),
    .ram_wdata         (ram_wdata),
    .ram_re            (ram_re),
    .ram_raddr         (ram_raddr),
    .ram_rdata         (ram_rdata),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_value         (out_value),
    .out_tap_index     (out_tap_index),
    .out_element_index (out_element_index),
    .out_ready_res     (out_ready_res),
    .out_last          (out_last)
  );

endmodule
